// File: hdl/mspid_pkg.sv
`default_nettype none
// ============================================================================
// Motor speed PID package
// Shared types and constants for the incremental motor speed controller.
// ============================================================================
package mspid_pkg;

    localparam int SPEED_W     = 16;
    localparam int ERR_W       = 17;
    localparam int GAIN_W      = 16;
    localparam int COMP_W      = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_HI = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_LO = 3'd4;

    localparam logic [GAIN_W-1:0] RST_GAIN_P  = 16'd1500;
    localparam logic [GAIN_W-1:0] RST_GAIN_I  = 16'd3000;
    localparam logic [GAIN_W-1:0] RST_GAIN_D  = 16'd300;
    localparam logic [COMP_W-1:0] RST_DUTY_HI = 16'd16799;
    localparam logic [COMP_W-1:0] RST_DUTY_LO = 16'd0;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [COMP_W-1:0] duty_hi;
        logic [COMP_W-1:0] duty_lo;
    } cfg_t;

    typedef struct packed {
        logic                      running;
        logic signed [SPEED_W-1:0] setpoint;
        logic signed [ERR_W-1:0]   err_latest;
        logic signed [ERR_W-1:0]   err_before;
        logic [COMP_W-1:0]         u;
    } state_t;

    typedef struct packed {
        logic [COMP_W-1:0] forward;
        logic [COMP_W-1:0] reverse;
        logic              direction;
    } result_t;

endpackage
`default_nettype wire

// File: hdl/motor_speed_incremental_pid_top.sv
`default_nettype none
// ============================================================================
// Motor speed incremental PID, top level
// Velocity-form PID speed controller with PWM compare outputs.
// ============================================================================
// Flow: a request waits in the request register; when it fires, the PID update
// and clamp settle combinationally and any result goes to the result register.
// Throughput: one request per cycle while a held result does not stall it.
// Reset: asynchronous, active low; clears the controller state, empties both
// registers and loads the default gains and duty limits.
module motor_speed_incremental_pid_top #(
    parameter int SPEED_FRAC_BITS = 8,
    parameter int DUTY_BITS       = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          command,
    input  wire logic signed [mspid_pkg::SPEED_W-1:0] measured_speed,
    input  wire logic signed [mspid_pkg::SPEED_W-1:0] target_speed,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [mspid_pkg::COMP_W-1:0]             forward_compare,
    output logic [mspid_pkg::COMP_W-1:0]             reverse_compare,
    output logic                                     drive_direction,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mspid_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mspid_pkg::COMP_W-1:0]        cfg_data
);
    import mspid_pkg::*;

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    emit;
    logic    req_valid_reg;
    cmd_t    req_cmd_reg;
    logic signed [SPEED_W-1:0] req_meas_reg;
    logic signed [SPEED_W-1:0] req_tgt_reg;
    logic    out_valid_reg;
    logic    req_fire;

    assign cfg_ready = 1'b1;

    mspid_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mspid_update #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .DUTY_BITS       (DUTY_BITS)
    ) u_update (
        .cmd        (req_cmd_reg),
        .meas       (req_meas_reg),
        .tgt        (req_tgt_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .emit       (emit),
        .result     (res_next)
    );

    assign req_fire = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || req_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            req_cmd_reg   <= CMD_TICK;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
            req_cmd_reg   <= cmd_t'(command);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            req_meas_reg <= measured_speed;
            req_tgt_reg  <= target_speed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (req_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign forward_compare = res_reg.forward;
    assign reverse_compare = res_reg.reverse;
    assign drive_direction = res_reg.direction;

    a_reverse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.reverse == '0)
        else $error("Reverse compare is nonzero on a valid result.");

    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.direction) |-> res_reg.forward == '0)
        else $error("Stopped result carries a nonzero forward compare.");

    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req_cmd_reg == CMD_STOP) |=> !state_reg.running)
        else $error("Controller still running after a stop request.");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !req_valid_reg |-> in_ready)
        else $error("Input not ready while the request register is empty.");

endmodule
`default_nettype wire

// File: hdl/mspid_cfg_regs.sv
`default_nettype none
// ============================================================================
// Motor speed PID configuration registers
// Holds the gains and duty limits, written through the configuration port.
// ============================================================================
module mspid_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [mspid_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mspid_pkg::COMP_W-1:0]        cfg_data,
    output mspid_pkg::cfg_t                          cfg
);
    import mspid_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_P:  cfg_next.gain_p  = cfg_data;
                REG_GAIN_I:  cfg_next.gain_i  = cfg_data;
                REG_GAIN_D:  cfg_next.gain_d  = cfg_data;
                REG_DUTY_HI: cfg_next.duty_hi = cfg_data;
                REG_DUTY_LO: cfg_next.duty_lo = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p  <= RST_GAIN_P;
            cfg_reg.gain_i  <= RST_GAIN_I;
            cfg_reg.gain_d  <= RST_GAIN_D;
            cfg_reg.duty_hi <= RST_DUTY_HI;
            cfg_reg.duty_lo <= RST_DUTY_LO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: hdl/mspid_update.sv
`default_nettype none
// ============================================================================
// Motor speed PID update
// Decodes one request and forms the next controller state and the result.
// ============================================================================
module mspid_update #(
    parameter int SPEED_FRAC_BITS = 8,
    parameter int DUTY_BITS       = 16
) (
    input  wire mspid_pkg::cmd_t                       cmd,
    input  wire logic signed [mspid_pkg::SPEED_W-1:0]  meas,
    input  wire logic signed [mspid_pkg::SPEED_W-1:0]  tgt,
    input  wire mspid_pkg::state_t                     state,
    input  wire mspid_pkg::cfg_t                       cfg,
    output mspid_pkg::state_t                          state_next,
    output logic                                       emit,
    output mspid_pkg::result_t                         result
);
    import mspid_pkg::*;

    localparam int DP_W   = ERR_W + 1;
    localparam int DD_W   = ERR_W + 2;
    localparam int PP_W   = DP_W + GAIN_W + 1;
    localparam int PD_W   = DD_W + GAIN_W + 1;
    localparam int SUM_W  = PD_W + 2;
    localparam int DUTY_CAP = (DUTY_BITS >= COMP_W) ? ((1 << COMP_W) - 1)
                                                    : ((1 << DUTY_BITS) - 1);
    localparam logic [COMP_W-1:0] DUTY_TOP = COMP_W'(DUTY_CAP);

    logic signed [ERR_W-1:0] e0;
    logic signed [DP_W-1:0]  diff_p;
    logic signed [DP_W-1:0]  sum_i;
    logic signed [DD_W-1:0]  diff_d;
    logic signed [PP_W-1:0]  prod_p;
    logic signed [PP_W-1:0]  prod_i;
    logic signed [PD_W-1:0]  prod_d;
    logic signed [SUM_W-1:0] u_sum;
    logic signed [SUM_W-1:0] u_hi;
    logic [COMP_W-1:0]       lim_hi;
    logic [COMP_W-1:0]       lim_lo;
    logic [COMP_W-1:0]       u_sat;

    always_comb
    begin
        e0     = ERR_W'(state.setpoint) - ERR_W'(meas);
        diff_p = DP_W'(e0) - DP_W'(state.err_latest);
        sum_i  = DP_W'(e0) + DP_W'(state.err_latest);
        diff_d = DD_W'(e0) - (DD_W'(state.err_latest) <<< 1) + DD_W'(state.err_before);
        prod_p = PP_W'(diff_p) * PP_W'($signed({1'b0, cfg.gain_p}));
        prod_i = PP_W'(sum_i) * PP_W'($signed({1'b0, cfg.gain_i}));
        prod_d = PD_W'(diff_d) * PD_W'($signed({1'b0, cfg.gain_d}));
        u_sum  = SUM_W'($signed({1'b0, state.u}))
               + SUM_W'(prod_p >>> SPEED_FRAC_BITS)
               + SUM_W'(prod_i >>> SPEED_FRAC_BITS)
               + SUM_W'(prod_d >>> SPEED_FRAC_BITS);
        lim_hi = (cfg.duty_hi > DUTY_TOP) ? DUTY_TOP : cfg.duty_hi;
        lim_lo = (cfg.duty_lo > DUTY_TOP) ? DUTY_TOP : cfg.duty_lo;
        u_hi   = (u_sum > SUM_W'($signed({1'b0, lim_hi})))
               ? SUM_W'($signed({1'b0, lim_hi})) : u_sum;
        u_sat  = (u_hi < SUM_W'($signed({1'b0, lim_lo}))) ? lim_lo : u_hi[COMP_W-1:0];
    end

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = '0;
        case (cmd)
            CMD_SET:
            begin
                state_next.setpoint = tgt;
                state_next.running  = 1'b1;
            end
            CMD_STOP:
            begin
                state_next.running = 1'b0;
                emit               = 1'b1;
            end
            CMD_CLEAR:
            begin
                state_next.err_latest = '0;
                state_next.err_before = '0;
                state_next.u          = '0;
                state_next.setpoint   = '0;
            end
            CMD_TICK:
            begin
                if (state.running)
                begin
                    state_next.err_before = state.err_latest;
                    state_next.err_latest = e0;
                    state_next.u          = u_sat;
                    if (state.setpoint == '0)
                    begin
                        state_next.u = '0;
                        emit         = 1'b1;
                    end
                    else if (!state.setpoint[SPEED_W-1])
                    begin
                        emit             = 1'b1;
                        result.forward   = u_sat;
                        result.direction = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: tb/sv/motor_speed_incremental_pid_top_test.sv
`default_nettype none
// ============================================================================
// Motor speed incremental PID testbench
// Sends directed and random speed requests through the valid/ready input,
// predicts each duty result with its own velocity-form PID model, and
// compares every result field by field across several gain and limit
// settings and several idling patterns on both channels.
// ============================================================================
module motor_speed_incremental_pid_top_test;

    import mspid_pkg::*;

    localparam int FRAC_BITS   = 8;
    localparam int DUTY_W      = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 165;

    typedef struct {
        cmd_t                      cmd;
        logic signed [SPEED_W-1:0] meas;
        logic signed [SPEED_W-1:0] tgt;
    } speed_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    cmd_t                      command = CMD_TICK;
    logic signed [SPEED_W-1:0] measured_speed = '0;
    logic signed [SPEED_W-1:0] target_speed = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [COMP_W-1:0]         forward_compare;
    logic [COMP_W-1:0]         reverse_compare;
    logic                      drive_direction;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = REG_GAIN_P;
    logic [COMP_W-1:0]         cfg_data = '0;

    speed_req_t speed_requests[$];
    result_t    duty_expect[$];
    speed_req_t next_req;
    result_t    due;

    int  queued_count = 0;
    int  taken_count = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  gen_target = 0;
    bit  req_fire = 1'b0;
    bit  res_fire = 1'b0;
    bit  cfg_fire = 1'b0;
    bit  draining = 1'b0;

    cfg_t                      model_cfg = {RST_GAIN_P, RST_GAIN_I, RST_GAIN_D,
                                            RST_DUTY_HI, RST_DUTY_LO};
    bit                        model_running = 1'b0;
    logic signed [SPEED_W-1:0] model_setpoint = '0;
    logic signed [ERR_W-1:0]   model_err_latest = '0;
    logic signed [ERR_W-1:0]   model_err_before = '0;
    longint                    model_u = 0;

    motor_speed_incremental_pid_top #(
        .SPEED_FRAC_BITS(FRAC_BITS),
        .DUTY_BITS(DUTY_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .measured_speed(measured_speed),
        .target_speed(target_speed),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .forward_compare(forward_compare),
        .reverse_compare(reverse_compare),
        .drive_direction(drive_direction),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic void predict_duty(input cmd_t cmd,
                                         input logic signed [SPEED_W-1:0] meas,
                                         input logic signed [SPEED_W-1:0] tgt);
        longint  e0;
        longint  e1;
        longint  e2;
        longint  u;
        result_t r;
        r = '0;
        case (cmd)
            CMD_SET:
            begin
                model_setpoint = tgt;
                model_running = 1'b1;
            end
            CMD_STOP:
            begin
                model_running = 1'b0;
                duty_expect.push_back(r);
            end
            CMD_CLEAR:
            begin
                model_err_latest = '0;
                model_err_before = '0;
                model_u = 0;
                model_setpoint = '0;
            end
            default:
            begin
                if (model_running)
                begin
                    e2 = longint'(model_err_before);
                    e1 = longint'(model_err_latest);
                    e0 = longint'(model_setpoint) - longint'(meas);
                    model_err_before = model_err_latest;
                    model_err_latest = e0[ERR_W-1:0];
                    u = model_u;
                    u += (longint'(model_cfg.gain_p) * (e0 - e1)) >>> FRAC_BITS;
                    u += (longint'(model_cfg.gain_i) * (e0 + e1)) >>> FRAC_BITS;
                    u += (longint'(model_cfg.gain_d) * (e0 - 2 * e1 + e2)) >>> FRAC_BITS;
                    if (u > longint'(model_cfg.duty_hi))
                        u = longint'(model_cfg.duty_hi);
                    if (u < longint'(model_cfg.duty_lo))
                        u = longint'(model_cfg.duty_lo);
                    model_u = u;
                    if (model_setpoint > 0)
                    begin
                        r.forward = u[COMP_W-1:0];
                        r.direction = 1'b1;
                        duty_expect.push_back(r);
                    end
                    else if (model_setpoint == 0)
                    begin
                        model_u = 0;
                        duty_expect.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    function automatic speed_req_t random_request();
        speed_req_t r;
        int         pick;
        pick = $urandom_range(99);
        r.cmd = CMD_TICK;
        r.meas = SPEED_W'($urandom);
        r.tgt = SPEED_W'($urandom);
        if (pick < 7)
        begin
            r.cmd = CMD_SET;
            if (pick < 4)
                r.tgt = SPEED_W'($urandom_range(1, 6000));
            else if (pick == 4)
                r.tgt = '0;
            gen_target = int'(r.tgt);
        end
        else if (pick < 10)
            r.cmd = CMD_STOP;
        else if (pick < 12)
            r.cmd = CMD_CLEAR;
        else if (pick < 80)
            r.meas = SPEED_W'(gen_target + int'($urandom_range(0, 64)) - 32);
        return r;
    endfunction

    task automatic queue_request(input cmd_t cmd, input logic [SPEED_W-1:0] meas,
                                 input logic [SPEED_W-1:0] tgt);
        speed_req_t r;
        r.cmd = cmd;
        r.meas = meas;
        r.tgt = tgt;
        speed_requests.push_back(r);
        queued_count++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [COMP_W-1:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_fire);
    endtask

    task automatic configure(input int phase);
        logic [COMP_W-1:0] p;
        logic [COMP_W-1:0] i;
        logic [COMP_W-1:0] d;
        logic [COMP_W-1:0] hi;
        logic [COMP_W-1:0] lo;
        p = COMP_W'($urandom_range(0, 4000));
        i = COMP_W'($urandom_range(0, 4000));
        d = COMP_W'($urandom_range(0, 4000));
        hi = COMP_W'($urandom_range(1000, 65535));
        lo = COMP_W'($urandom_range(0, hi / 2));
        case (phase)
            1:
            begin
                p = 16'hFFFF; i = 16'hFFFF; d = 16'hFFFF; hi = 16'hFFFF; lo = '0;
            end
            2:
            begin
                p = '0; i = '0; d = '0; hi = 16'hFFFF; lo = 16'hFFFF;
            end
            3:
            begin
                p = RST_GAIN_P; i = RST_GAIN_I; d = RST_GAIN_D; hi = '0; lo = 16'd20000;
            end
            5:
            begin
                p = RST_GAIN_P; i = RST_GAIN_I; d = RST_GAIN_D;
                hi = RST_DUTY_HI; lo = RST_DUTY_LO;
            end
            default:
            begin
            end
        endcase
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_DUTY_HI, hi);
        write_reg(REG_DUTY_LO, lo);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (taken_count != queued_count || duty_expect.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && (!in_valid || req_fire))
        begin
            if (draining && duty_expect.size() == 0)
                draining = 1'b0;
            else if (!draining && speed_requests.size() > 0 && $urandom_range(149) == 0)
                draining = 1'b1;
            if (!draining && speed_requests.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                next_req = speed_requests.pop_front();
                command <= next_req.cmd;
                measured_speed <= next_req.meas;
                target_speed <= next_req.tgt;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        req_fire = rst_n && in_valid && in_ready;
        res_fire = rst_n && out_valid && out_ready;
        cfg_fire = rst_n && cfg_valid && cfg_ready;
        if (res_fire)
        begin
            if (duty_expect.size() == 0)
                report_mismatch("result with none expected, forward_compare",
                                forward_compare, 0);
            else
            begin
                due = duty_expect.pop_front();
                if (forward_compare !== due.forward)
                    report_mismatch("forward_compare", forward_compare, due.forward);
                if (reverse_compare !== due.reverse)
                    report_mismatch("reverse_compare", reverse_compare, due.reverse);
                if (drive_direction !== due.direction)
                    report_mismatch("drive_direction", drive_direction, due.direction);
            end
        end
        if (req_fire)
        begin
            predict_duty(command, measured_speed, target_speed);
            taken_count++;
        end
        if (cfg_fire)
        begin
            case (cfg_index)
                REG_GAIN_P:  model_cfg.gain_p = cfg_data;
                REG_GAIN_I:  model_cfg.gain_i = cfg_data;
                REG_GAIN_D:  model_cfg.gain_d = cfg_data;
                REG_DUTY_HI: model_cfg.duty_hi = cfg_data;
                REG_DUTY_LO: model_cfg.duty_lo = cfg_data;
                default:
                begin
                end
            endcase
        end
        if (req_fire || res_fire || cfg_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_request(CMD_TICK, 16'h1234, 16'h0000);
        queue_request(CMD_STOP, 16'h0000, 16'h0000);
        queue_request(CMD_SET, 16'h0000, 16'h0100);
        queue_request(CMD_TICK, 16'h0000, 16'h0000);
        queue_request(CMD_TICK, 16'h0080, 16'h0000);
        queue_request(CMD_TICK, 16'h0100, 16'h0000);
        queue_request(CMD_TICK, 16'h7FFF, 16'h0000);
        queue_request(CMD_TICK, 16'h8000, 16'h0000);
        queue_request(CMD_SET, 16'h0000, 16'h7FFF);
        queue_request(CMD_TICK, 16'h8000, 16'h0000);
        queue_request(CMD_TICK, 16'h7FFF, 16'h0000);
        queue_request(CMD_SET, 16'h0000, 16'h8000);
        queue_request(CMD_TICK, 16'h7FFF, 16'h0000);
        queue_request(CMD_TICK, 16'h0000, 16'h0000);
        queue_request(CMD_SET, 16'hFFFF, 16'h0000);
        queue_request(CMD_TICK, 16'h0040, 16'h0000);
        queue_request(CMD_SET, 16'h0000, 16'h0200);
        queue_request(CMD_TICK, 16'h0100, 16'h0000);
        queue_request(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_TICK, 16'h0010, 16'h0000);
        queue_request(CMD_SET, 16'h0000, 16'hFFFF);
        queue_request(CMD_TICK, 16'hFFFF, 16'h0000);
        queue_request(CMD_STOP, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_TICK, 16'h0000, 16'h0300);
        queue_request(CMD_CLEAR, 16'h0000, 16'h0000);
        wait_drained();

        for (phase = 1; phase <= 5; phase++)
        begin
            configure(phase);
            case (phase % 4)
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                3:       begin idle_pct = 6;  stall_pct = 6;  end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                speed_requests.push_back(random_request());
                queued_count++;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
